FILE: rtl/tglw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tglw_pkg: shared types and constants for the text glyph layout unit
// Holds the cursor state, item, result and register structs, the font
// metrics and the register indexes.
// ----------------------------------------------------------------------------
package tglw_pkg;

  // register indexes on the write port
  localparam logic [1:0] CfgFontSize     = 2'd0;
  localparam logic [1:0] CfgScreenLength = 2'd1;
  localparam logic [1:0] CfgScreenHeight = 2'd2;

  // font metrics, small and large font
  localparam logic [4:0] NarrowSmall = 5'd6;
  localparam logic [4:0] NarrowLarge = 5'd8;
  localparam logic [4:0] WideSmall   = 5'd12;
  localparam logic [4:0] WideLarge   = 5'd16;
  localparam logic [4:0] StepSmall   = 5'd13;
  localparam logic [4:0] StepLarge   = 5'd16;

  // byte classes
  localparam logic [7:0] ByteEnd        = 8'h00;
  localparam logic [7:0] PrintFirst     = 8'd32;
  localparam logic [7:0] PrintLast      = 8'd126;
  localparam logic [7:0] CtrlLast       = 8'd31;
  localparam logic [7:0] ByteDel        = 8'd127;

  // register reset values
  localparam logic [11:0] ScreenLengthRst = 12'd128;
  localparam logic [11:0] ScreenHeightRst = 12'd64;

  typedef struct packed {
    logic        font_size;
    logic [11:0] screen_length;
    logic [11:0] screen_height;
  } tglw_cfg_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        string_start;
    logic [11:0] start_x;
    logic [11:0] start_y;
  } tglw_item_t;

  typedef struct packed {
    logic        wide_glyph;
    logic [15:0] char_code;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } tglw_word_t;

  typedef struct packed {
    logic [12:0] cursor_x;
    logic [12:0] cursor_y;
    logic        lead_pending;
    logic [7:0]  lead_byte;
    logic        halted;
  } tglw_state_t;

endpackage

FILE: rtl/tglw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tglw_step: layout step for one text byte
// Classifies the byte, tracks the lead byte of wide characters, applies the
// wrap test and the screen height stop, and gives the next cursor state.
// ----------------------------------------------------------------------------
module tglw_step (
  input  tglw_pkg::tglw_cfg_t   cfg_i,
  input  tglw_pkg::tglw_item_t  item_i,
  input  tglw_pkg::tglw_state_t state_i,
  output tglw_pkg::tglw_state_t state_o,
  output logic                  emit_o,
  output tglw_pkg::tglw_word_t  word_o
);

  tglw_pkg::tglw_state_t st;
  logic        place;
  logic        wide;
  logic [15:0] code;
  logic [4:0]  glyph_w;
  logic [4:0]  line_step;
  logic [13:0] x_end;
  logic        wrap;
  logic [12:0] x_wrap;
  logic [12:0] y_wrap;

  // byte decode and lead byte tracking
  always_comb begin
    st      = state_i;
    place   = 1'b0;
    wide    = 1'b0;
    code    = {8'h00, item_i.text_byte};
    glyph_w = cfg_i.font_size ? tglw_pkg::NarrowLarge : tglw_pkg::NarrowSmall;
    if (item_i.string_start) begin
      st.cursor_x     = {1'b0, item_i.start_x};
      st.cursor_y     = {1'b0, item_i.start_y};
      st.lead_pending = 1'b0;
      st.lead_byte    = '0;
      st.halted       = 1'b0;
    end
    if (!st.halted) begin
      if (item_i.text_byte == tglw_pkg::ByteEnd) begin
        st.lead_pending = 1'b0;
        st.lead_byte    = '0;
        st.halted       = 1'b1;
      end else if (st.lead_pending) begin
        st.lead_pending = 1'b0;
        place   = 1'b1;
        wide    = 1'b1;
        code    = {item_i.text_byte, st.lead_byte};
        glyph_w = cfg_i.font_size ? tglw_pkg::WideLarge : tglw_pkg::WideSmall;
      end else if (item_i.text_byte inside {[tglw_pkg::PrintFirst : tglw_pkg::PrintLast]}) begin
        place = 1'b1;
      end else if (!cfg_i.font_size &&
                   (item_i.text_byte <= tglw_pkg::CtrlLast ||
                    item_i.text_byte == tglw_pkg::ByteDel)) begin
        // control byte skipped in the small font
        place = 1'b0;
      end else begin
        st.lead_byte    = item_i.text_byte;
        st.lead_pending = 1'b1;
      end
    end
  end

  // wrap test against the right edge
  assign line_step = cfg_i.font_size ? tglw_pkg::StepLarge : tglw_pkg::StepSmall;
  assign x_end     = {1'b0, st.cursor_x} + {9'd0, glyph_w};
  assign wrap      = x_end > {2'b00, cfg_i.screen_length};
  assign x_wrap    = wrap ? 13'd0 : st.cursor_x;
  assign y_wrap    = wrap ? st.cursor_y + {8'd0, line_step} : st.cursor_y;

  // placement, height stop and cursor advance
  always_comb begin
    state_o = st;
    emit_o  = 1'b0;
    word_o  = '0;
    if (place) begin
      state_o.cursor_x = x_wrap;
      state_o.cursor_y = y_wrap;
      if (y_wrap >= {1'b0, cfg_i.screen_height}) begin
        state_o.halted = 1'b1;
      end else begin
        emit_o            = 1'b1;
        word_o.wide_glyph = wide;
        word_o.char_code  = code;
        word_o.pos_x      = x_wrap[11:0];
        word_o.pos_y      = y_wrap[11:0];
        state_o.cursor_x  = x_wrap + {8'd0, glyph_w};
      end
    end
  end

endmodule

FILE: rtl/text_glyph_layout_with_wrap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_layout_with_wrap_unit: text byte stream to glyph placements
// A byte waits in the input register; its word moves into the output register
// when that is free. Throughput: one byte per cycle while the output is not
// stalled; the cursor update is one add and compare between the two registers.
// Reset: cursor and lead byte cleared, unit halted until a string start,
// font_size 0, screen 128 by 64; both pipeline registers empty.
// ----------------------------------------------------------------------------
module text_glyph_layout_with_wrap_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // register write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        string_start_i,
  input  logic [11:0] start_x_i,
  input  logic [11:0] start_y_i,
  // glyph output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        wide_glyph_o,
  output logic [15:0] char_code_o,
  output logic [11:0] pos_x_o,
  output logic [11:0] pos_y_o
);

  tglw_pkg::tglw_cfg_t   cfg_q;
  tglw_pkg::tglw_item_t  item_q;
  logic                  in_vld_q;
  tglw_pkg::tglw_state_t st_q, st_d;
  tglw_pkg::tglw_word_t  word_q, word_d;
  logic                  out_vld_q;
  logic                  emit;
  logic                  adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_size     <= 1'b0;
      cfg_q.screen_length <= tglw_pkg::ScreenLengthRst;
      cfg_q.screen_height <= tglw_pkg::ScreenHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tglw_pkg::CfgFontSize:     cfg_q.font_size     <= cfg_data_i[0];
        tglw_pkg::CfgScreenLength: cfg_q.screen_length <= cfg_data_i;
        tglw_pkg::CfgScreenHeight: cfg_q.screen_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: input word moves on when the output register is free
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{text_byte: text_byte_i, string_start: string_start_i,
                  start_x: start_x_i, start_y: start_y_i};
    end
  end

  // layout step
  tglw_step u_step (
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_i (st_q),
    .state_o (st_d),
    .emit_o  (emit),
    .word_o  (word_d)
  );

  // cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cursor_x: '0, cursor_y: '0, lead_pending: 1'b0,
                lead_byte: '0, halted: 1'b1};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= emit;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign wide_glyph_o = word_q.wide_glyph;
  assign char_code_o  = word_q.char_code;
  assign pos_x_o      = word_q.pos_x;
  assign pos_y_o      = word_q.pos_y;

  // checks
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("input register empty but not ready");

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && st_q.halted && !item_q.string_start |-> !emit)
    else $error("glyph emitted while halted");

  a_row_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> {1'b0, word_d.pos_y} < {1'b0, cfg_q.screen_height})
    else $error("glyph placed below screen height");

  a_end_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && item_q.text_byte == tglw_pkg::ByteEnd |=> st_q.halted && !st_q.lead_pending)
    else $error("terminator did not halt");

endmodule

FILE: tb/sv/glyph_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_check_pkg: glyph placement scoreboard for the text layout unit
// Keeps its own cursor, lead byte and screen registers, predicts the glyph
// word caused by every byte taken and checks output words in order.
// ----------------------------------------------------------------------------
package glyph_check_pkg;

  import tglw_pkg::*;

  class glyph_scoreboard;
    tglw_cfg_t   regs;
    tglw_state_t cur;
    tglw_word_t  placements_due[$];
    int unsigned taken_bytes;
    int unsigned mismatches;

    function new();
      regs.font_size     = 1'b0;
      regs.screen_length = ScreenLengthRst;
      regs.screen_height = ScreenHeightRst;
      cur                = '0;
      cur.halted         = 1'b1;
      taken_bytes        = 0;
      mismatches         = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        CfgFontSize:     regs.font_size = data[0];
        CfgScreenLength: regs.screen_length = data;
        CfgScreenHeight: regs.screen_height = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return placements_due.size();
    endfunction

    // wrap if the glyph crosses the right edge, then place it unless off screen
    function void place_glyph(logic wide, logic [15:0] code, logic [4:0] width);
      tglw_word_t g;
      logic [4:0] step;
      step = regs.font_size ? StepLarge : StepSmall;
      if (int'(cur.cursor_x) + int'(width) > int'(regs.screen_length)) begin
        cur.cursor_y = cur.cursor_y + {8'd0, step};
        cur.cursor_x = '0;
      end
      if (cur.cursor_y >= {1'b0, regs.screen_height}) begin
        cur.halted = 1'b1;
        return;
      end
      g.wide_glyph = wide;
      g.char_code  = code;
      g.pos_x      = cur.cursor_x[11:0];
      g.pos_y      = cur.cursor_y[11:0];
      placements_due.push_back(g);
      cur.cursor_x = cur.cursor_x + {8'd0, width};
    endfunction

    // one byte taken by the unit
    function void note_byte(tglw_item_t it);
      logic       big_font;
      logic [7:0] b;
      big_font = regs.font_size;
      b        = it.text_byte;
      taken_bytes++;
      if (it.string_start) begin
        cur.cursor_x     = {1'b0, it.start_x};
        cur.cursor_y     = {1'b0, it.start_y};
        cur.lead_pending = 1'b0;
        cur.lead_byte    = '0;
        cur.halted       = 1'b0;
      end
      if (cur.halted) return;
      // terminator drops any pending lead byte
      if (b == ByteEnd) begin
        cur.lead_pending = 1'b0;
        cur.lead_byte    = '0;
        cur.halted       = 1'b1;
        return;
      end
      // any nonzero byte completes a wide character
      if (cur.lead_pending) begin
        cur.lead_pending = 1'b0;
        place_glyph(1'b1, {b, cur.lead_byte}, big_font ? WideLarge : WideSmall);
        return;
      end
      if (b >= PrintFirst && b <= PrintLast) begin
        place_glyph(1'b0, {8'h00, b}, big_font ? NarrowLarge : NarrowSmall);
        return;
      end
      // control bytes are skipped in the small font
      if (!big_font && (b <= CtrlLast || b == ByteDel)) return;
      cur.lead_byte    = b;
      cur.lead_pending = 1'b1;
    endfunction

    // one word taken from the unit
    function void check_glyph(tglw_word_t got);
      tglw_word_t want;
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: wide=%0d code=%h x=%0d y=%0d",
                   got.wide_glyph, got.char_code, got.pos_x, got.pos_y);
        return;
      end
      want = placements_due.pop_front();
      if (got.wide_glyph !== want.wide_glyph || got.char_code !== want.char_code ||
          got.pos_x !== want.pos_x || got.pos_y !== want.pos_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp wide=%0d code=%h x=%0d y=%0d, got %0d %h %0d %0d",
                   want.wide_glyph, want.char_code, want.pos_x, want.pos_y,
                   got.wide_glyph, got.char_code, got.pos_x, got.pos_y);
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/text_glyph_layout_with_wrap_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_glyph_layout_with_wrap_unit_test: testbench of the text layout unit
// Directed strings cover every byte class, wrap, halt and lead byte drop,
// then random strings run under several screen settings with random idling
// on both sides, a long output hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module text_glyph_layout_with_wrap_unit_test;

  import tglw_pkg::*;
  import glyph_check_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int HoldCycles = 400;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = CfgFontSize;
  logic [11:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i    = '0;
  logic        string_start_i = 1'b0;
  logic [11:0] start_x_i      = '0;
  logic [11:0] start_y_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        wide_glyph_o;
  logic [15:0] char_code_o;
  logic [11:0] pos_x_o;
  logic [11:0] pos_y_o;

  glyph_scoreboard sb;
  int unsigned     idle_pct     = 0;
  int unsigned     stall_pct    = 0;
  bit              hold_req     = 1'b0;
  int              hold_left    = 0;
  int              quiet_cycles = 0;

  text_glyph_layout_with_wrap_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .string_start_i (string_start_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .wide_glyph_o   (wide_glyph_o),
    .char_code_o    (char_code_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // handshakes seen at the edge: words checked first, then the byte noted
  always @(posedge clk_i) begin : port_watch
    tglw_word_t seen;
    tglw_item_t taken;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.wide_glyph = wide_glyph_o;
        seen.char_code  = char_code_o;
        seen.pos_x      = pos_x_o;
        seen.pos_y      = pos_y_o;
        sb.check_glyph(seen);
      end
      if (in_valid_i && in_ready_o) begin
        taken.text_byte    = text_byte_i;
        taken.string_start = string_start_i;
        taken.start_x      = start_x_i;
        taken.start_y      = start_y_i;
        sb.note_byte(taken);
      end
    end
  end

  // output side: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin : receiver
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // stop the run when no word moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one byte, with random idle cycles ahead of it
  task automatic send_byte(logic [7:0] b, logic s, logic [11:0] x, logic [11:0] y);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    text_byte_i    <= b;
    string_start_i <= s;
    start_x_i      <= x;
    start_y_i      <= y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // random 12-bit coordinate
  function automatic logic [11:0] any_pos();
    return 12'($urandom_range(0, 4095));
  endfunction

  // mostly printable, some wide leads, control bytes and stray terminators
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(PrintFirst, PrintLast));
    if (r < 75) return 8'($urandom_range(128, 255));
    if (r < 85) return ($urandom_range(0, 3) == 0) ? ByteDel : 8'($urandom_range(1, CtrlLast));
    if (r < 88) return ByteEnd;
    return 8'($urandom_range(0, 255));
  endfunction

  // one string: start position, random content, usually a terminator
  task automatic send_string();
    int unsigned n;
    int unsigned ymax;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  b;
    bit          lead;
    bit          s;
    n    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
    ymax = sb.regs.screen_height - 1;
    if ($urandom_range(0, 9) == 0) begin
      x = any_pos();
      y = any_pos();
    end else begin
      x = 12'($urandom_range(0, sb.regs.screen_length));
      y = $urandom_range(0, 1) ? 12'($urandom_range(0, ymax)) : 12'($urandom_range(0, ymax / 8));
    end
    lead = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (lead && $urandom_range(0, 9) != 0)
        b = 8'($urandom_range(1, 255));
      else
        b = pick_byte();
      lead = (b != ByteEnd) && (b < PrintFirst || b > PrintLast);
      s    = (i == 0) || ($urandom_range(0, 49) == 0);
      if (s)
        send_byte(b, 1'b1, x, y);
      else
        send_byte(b, 1'b0, any_pos(), any_pos());
    end
    if ($urandom_range(0, 9) != 0)
      send_byte(ByteEnd, 1'b0, any_pos(), any_pos());
    // bytes after the end are ignored until the next start
    if ($urandom_range(0, 19) == 0)
      repeat (3) send_byte(pick_byte(), 1'b0, any_pos(), any_pos());
  endtask

  // hold the input until every expected word has come, plus the latency
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_screen(logic f, logic [11:0] len, logic [11:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgFontSize;
    cfg_data_i <= {11'd0, f};
    @(posedge clk_i);
    sb.write_reg(CfgFontSize, {11'd0, f});
    cfg_idx_i  <= CfgScreenLength;
    cfg_data_i <= len;
    @(posedge clk_i);
    sb.write_reg(CfgScreenLength, len);
    cfg_idx_i  <= CfgScreenHeight;
    cfg_data_i <= h;
    @(posedge clk_i);
    sb.write_reg(CfgScreenHeight, h);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic f, logic [11:0] len, logic [11:0] h,
                           int unsigned idle, int unsigned stall);
    wait_drain();
    set_screen(f, len, h);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic feed(int unsigned count);
    int unsigned goal;
    goal = sb.taken_bytes + count;
    while (sb.taken_bytes < goal) send_string();
  endtask

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset screen, small font: every byte class on one line
    send_byte(8'h41, 1'b1, 12'd0, 12'd0);
    send_byte(8'h20, 1'b0, 12'd0, 12'd0);
    send_byte(8'h7E, 1'b0, 12'd0, 12'd0);
    send_byte(8'h80, 1'b0, 12'd0, 12'd0);
    send_byte(8'hFF, 1'b0, 12'd0, 12'd0);
    send_byte(8'h01, 1'b0, 12'd0, 12'd0);
    send_byte(ByteDel, 1'b0, 12'd0, 12'd0);
    // low second byte still completes the wide character
    send_byte(8'hC3, 1'b0, 12'd0, 12'd0);
    send_byte(8'h01, 1'b0, 12'd0, 12'd0);
    send_byte(ByteEnd, 1'b0, 12'd0, 12'd0);
    send_byte(8'h5A, 1'b0, 12'hFFF, 12'hFFF);
    // wrap at the right edge, then a lead byte dropped by the terminator
    send_byte(8'h42, 1'b1, 12'd125, 12'd0);
    send_byte(8'h90, 1'b0, 12'd0, 12'd0);
    send_byte(ByteEnd, 1'b0, 12'd0, 12'd0);
    // last row, then a wrap past the bottom halts
    send_byte(8'h43, 1'b1, 12'd0, 12'd60);
    send_byte(8'h44, 1'b1, 12'd126, 12'd60);
    send_byte(8'h45, 1'b0, 12'd0, 12'd0);
    // a new start drops a pending lead byte
    send_byte(8'hFF, 1'b1, 12'hFFF, 12'hFFF);
    send_byte(8'h46, 1'b1, 12'd0, 12'd0);

    // large font on the largest screen: control bytes lead wide characters
    wait_drain();
    set_screen(1'b1, 12'hFFF, 12'hFFF);
    send_byte(8'h01, 1'b1, 12'hFFF, 12'hFFF);
    send_byte(8'h20, 1'b0, 12'd0, 12'd0);
    send_byte(8'h47, 1'b1, 12'd4079, 12'd0);
    send_byte(ByteDel, 1'b0, 12'd0, 12'd0);
    send_byte(8'h41, 1'b0, 12'd0, 12'd0);
    send_byte(ByteEnd, 1'b0, 12'd0, 12'd0);

    // reset screen size, long output hold-off while bytes keep coming
    configure(1'b0, ScreenLengthRst, ScreenHeightRst, 0, 0);
    feed(120);
    hold_req = 1'b1;
    feed(125);

    configure(1'b1, 12'hFFF, 12'hFFF, 73, 0);
    feed(245);

    // narrowest screen: every glyph wraps
    configure(1'b0, 12'd1, 12'hFFF, 0, 73);
    feed(245);

    // single-row screen
    configure(1'b1, 12'd60, 12'd1, 27, 27);
    feed(245);

    // random screen, sender pauses until all words are out
    configure(1'b0, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), 27, 27);
    feed(120);
    wait_drain();
    feed(125);

    configure(1'($urandom_range(0, 1)), 12'($urandom_range(1, 300)),
              12'($urandom_range(1, 300)), 0, 0);
    feed(245);

    wait_drain();
    repeat (6) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tglw_pkg.sv
rtl/tglw_step.sv
rtl/text_glyph_layout_with_wrap_unit.sv
tb/sv/glyph_check_pkg.sv
tb/sv/text_glyph_layout_with_wrap_unit_test.sv
